[design/task_table_round_robin_scheduler_macros.svh]
// assertion macros shared by the task table scheduler rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef TASK_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TASK_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define TTRR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define TTRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTRR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TTRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[design/ttrr_pkg.sv]
// shared types and constants for the task table round-robin scheduler
// no dependencies; imported by the controller, datapath and top level
package ttrr_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  // request modes
  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_EXIT  = 3'd1;
  localparam logic [2:0] MODE_REAP  = 3'd2;
  localparam logic [2:0] MODE_SCHED = 3'd3;
  localparam logic [2:0] MODE_BLOCK = 3'd4;

  // per-slot task states
  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_EXITED  = 3'd4
  } slot_state_t;

  // match test applied to the entry under the table index
  typedef enum logic [1:0] {
    TEST_NONE,
    TEST_FREE,
    TEST_REAP,
    TEST_READY
  } test_t;

  // table action at the entry under the table index
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ALLOC,
    ACT_EXIT_SELF,
    ACT_EXIT_WAKE,
    ACT_REAP,
    ACT_SCHED_MARK,
    ACT_SCHED_OLD,
    ACT_SCHED_NEW
  } act_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  load;
    logic  adv;
    test_t test;
    act_t  act;
    logic  block;
    logic  publish;
  } ttrr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hit;
    logic at_end;
    logic at_old;
    logic slot_ok;
    logic par_ok;
  } ttrr_stat_t;

endpackage

[design/ttrr_datapath.sv]
// task table storage, scan index, counters and result registers
// depends on ttrr_pkg and the assertion macro header
`include "task_table_round_robin_scheduler_macros.svh"

module ttrr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ttrr_pkg::ttrr_cmd_t cmd,
  output ttrr_pkg::ttrr_stat_t stat,
  input  logic [2:0]          mode,
  input  logic [3:0]          slot,
  input  logic [3:0]          target,
  input  logic signed [31:0]  status,
  output logic                ok,
  output logic [3:0]          result_slot,
  output logic signed [31:0]  result_status,
  output logic [4:0]          ready_count,
  output logic [31:0]         switch_count
);
  import ttrr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  // task table
  slot_state_t       slot_state [TASK_SLOTS];
  logic [3:0]        parent_of  [TASK_SLOTS];
  logic [31:0]       status_of  [TASK_SLOTS];
  logic [3:0]        wait_for   [TASK_SLOTS];

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  nx;
  logic [IDX_W-1:0]  current;
  logic [CNT_W-1:0]  ready_cnt;
  logic [31:0]       switches;

  // latched request
  logic [2:0]        mode_r;
  logic [3:0]        slot_r;
  logic [3:0]        target_r;
  logic [31:0]       status_r;

  // pending result
  logic              ok_r;
  logic [IDX_W-1:0]  rslot_r;
  logic [31:0]       rstatus_r;

  slot_state_t       cur_state;
  logic [3:0]        cur_parent;
  logic [3:0]        cur_wait;
  logic [31:0]       cur_code;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  cur_inc;
  logic              wake;
  logic              ready_up;
  logic              ready_dn;
  logic              rslot_is_cur;

  // single read port at the table index
  assign cur_state  = slot_state[idx];
  assign cur_parent = parent_of[idx];
  assign cur_wait   = wait_for[idx];
  assign cur_code   = status_of[idx];

  // cyclic increments
  assign idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign cur_inc = (current == LAST_IDX) ? '0 : current + 1'b1;

  // blocked parent wakes on any child or on the matching one
  assign wake = (cur_state == ST_BLOCKED) &&
                ((cur_wait == 4'd0) || (cur_wait == slot_r));

  // status toward the controller
  always_comb begin
    case (cmd.test)
      TEST_FREE:  stat.hit = (cur_state == ST_FREE);
      TEST_REAP:  stat.hit = (cur_state == ST_EXITED) && (cur_parent == slot_r) &&
                             ((target_r == 4'd0) || (int'(idx) == int'(target_r)));
      TEST_READY: stat.hit = (cur_state == ST_READY);
      default:    stat.hit = 1'b0;
    endcase
    stat.at_end  = (idx == LAST_IDX);
    stat.at_old  = (idx == current);
    stat.slot_ok = (int'(slot) < TASK_SLOTS);
    stat.par_ok  = (int'(cur_parent) < TASK_SLOTS);
  end

  // ready count moves by at most one per cycle
  always_comb begin
    ready_up = 1'b0;
    ready_dn = 1'b0;
    case (cmd.act)
      ACT_ALLOC:     ready_up = 1'b1;
      ACT_EXIT_SELF: ready_dn = (cur_state == ST_READY);
      ACT_EXIT_WAKE: ready_up = wake;
      ACT_SCHED_OLD: ready_up = (cur_state == ST_RUNNING);
      ACT_SCHED_NEW: ready_dn = 1'b1;
      default: begin
        ready_up = 1'b0;
        ready_dn = 1'b0;
      end
    endcase
    if (cmd.block) begin
      ready_dn = (cur_state == ST_READY);
    end
  end

  // slot states
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
      end
    end else begin
      case (cmd.act)
        ACT_ALLOC:     slot_state[idx] <= ST_READY;
        ACT_EXIT_SELF: slot_state[idx] <= ST_EXITED;
        ACT_EXIT_WAKE: if (wake) slot_state[idx] <= ST_READY;
        ACT_REAP:      slot_state[idx] <= ST_FREE;
        ACT_SCHED_OLD: if (cur_state == ST_RUNNING) slot_state[idx] <= ST_READY;
        ACT_SCHED_NEW: slot_state[idx] <= ST_RUNNING;
        default: ;
      endcase
      if (cmd.block && ((cur_state == ST_RUNNING) || (cur_state == ST_READY))) begin
        slot_state[idx] <= ST_BLOCKED;
      end
    end
  end

  // parent, exit status and wait target per slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        parent_of[i] <= 4'd0;
        status_of[i] <= 32'd0;
        wait_for[i]  <= 4'd0;
      end
    end else begin
      case (cmd.act)
        ACT_ALLOC: begin
          parent_of[idx] <= slot_r;
          status_of[idx] <= 32'd0;
          wait_for[idx]  <= 4'd0;
        end
        ACT_EXIT_SELF: status_of[idx] <= status_r;
        ACT_REAP: begin
          parent_of[idx] <= 4'd0;
          status_of[idx] <= 32'd0;
          wait_for[idx]  <= 4'd0;
        end
        default: ;
      endcase
      if (cmd.block && ((cur_state == ST_RUNNING) || (cur_state == ST_READY))) begin
        wait_for[idx] <= target_r;
      end
    end
  end

  // table index and scheduler registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      nx        <= '0;
      current   <= '0;
      switches  <= 32'd0;
      ready_cnt <= '0;
    end else begin
      if (cmd.load) begin
        case (mode)
          MODE_SCHED: idx <= cur_inc;
          MODE_EXIT:  idx <= IDX_W'(slot);
          MODE_BLOCK: idx <= IDX_W'(slot);
          default:    idx <= '0;
        endcase
      end else if (cmd.adv) begin
        idx <= idx_inc;
      end else begin
        case (cmd.act)
          ACT_EXIT_SELF: idx <= IDX_W'(cur_parent);
          ACT_SCHED_MARK: begin
            nx  <= idx;
            idx <= current;
          end
          ACT_SCHED_OLD: idx <= nx;
          default: ;
        endcase
      end
      if (cmd.act == ACT_SCHED_NEW) begin
        current  <= idx;
        switches <= switches + 32'd1;
      end
      if (ready_up) begin
        ready_cnt <= ready_cnt + 1'b1;
      end else if (ready_dn) begin
        ready_cnt <= ready_cnt - 1'b1;
      end
    end
  end

  // request latch and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode;
      slot_r    <= slot;
      target_r  <= target;
      status_r  <= status;
      ok_r      <= 1'b0;
      rslot_r   <= '0;
      rstatus_r <= 32'd0;
    end else begin
      case (cmd.act)
        ACT_ALLOC: begin
          ok_r    <= 1'b1;
          rslot_r <= idx;
        end
        ACT_REAP: begin
          ok_r      <= 1'b1;
          rslot_r   <= idx;
          rstatus_r <= cur_code;
        end
        ACT_SCHED_NEW: ok_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign rslot_is_cur = (mode_r != MODE_ALLOC) && (mode_r != MODE_REAP);

  // output registers, loaded once per request
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      ok            <= ok_r;
      result_slot   <= 4'(rslot_is_cur ? current : rslot_r);
      result_status <= rstatus_r;
      ready_count   <= 5'(ready_cnt);
      switch_count  <= switches;
    end
  end

  `TTRR_ASSERT_IMPL(a_ready_range, clk, rst, 1'b1, int'(ready_cnt) <= TASK_SLOTS, "ready count out of range")
  `TTRR_ASSERT_IMPL(a_one_running, clk, rst, cmd.act == ACT_SCHED_NEW, cur_state == ST_READY, "dispatch of a slot that is not ready")
  `TTRR_ASSERT_NEXT(a_switch_step, clk, rst, cmd.act == ACT_SCHED_NEW, switches == $past(switches) + 32'd1, "switch count did not advance")

endmodule

[design/ttrr_controller.sv]
// sequencing state machine for the task table scheduler
// depends on ttrr_pkg and the assertion macro header
`include "task_table_round_robin_scheduler_macros.svh"

module ttrr_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           mode,
  input  ttrr_pkg::ttrr_stat_t stat,
  output ttrr_pkg::ttrr_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import ttrr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_EXIT_SELF,
    S_EXIT_WAKE,
    S_REAP_SCAN,
    S_SCHED_SCAN,
    S_SCHED_OLD,
    S_SCHED_NEW,
    S_BLOCK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (mode)
            MODE_ALLOC: state_next = S_ALLOC_SCAN;
            MODE_EXIT:  state_next = stat.slot_ok ? S_EXIT_SELF : S_FINISH;
            MODE_REAP:  state_next = stat.slot_ok ? S_REAP_SCAN : S_FINISH;
            MODE_SCHED: state_next = S_SCHED_SCAN;
            MODE_BLOCK: state_next = stat.slot_ok ? S_BLOCK : S_FINISH;
            default:    state_next = S_FINISH;
          endcase
        end
      end
      S_ALLOC_SCAN: begin
        cmd.test = TEST_FREE;
        if (stat.hit) begin
          cmd.act    = ACT_ALLOC;
          state_next = S_FINISH;
        end else if (stat.at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_EXIT_SELF: begin
        cmd.act    = ACT_EXIT_SELF;
        state_next = stat.par_ok ? S_EXIT_WAKE : S_FINISH;
      end
      S_EXIT_WAKE: begin
        cmd.act    = ACT_EXIT_WAKE;
        state_next = S_FINISH;
      end
      S_REAP_SCAN: begin
        cmd.test = TEST_REAP;
        if (stat.hit) begin
          cmd.act    = ACT_REAP;
          state_next = S_FINISH;
        end else if (stat.at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_SCHED_SCAN: begin
        cmd.test = TEST_READY;
        if (stat.hit) begin
          cmd.act    = ACT_SCHED_MARK;
          state_next = S_SCHED_OLD;
        end else if (stat.at_old) begin
          state_next = S_FINISH;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_SCHED_OLD: begin
        cmd.act    = ACT_SCHED_OLD;
        state_next = S_SCHED_NEW;
      end
      S_SCHED_NEW: begin
        cmd.act    = ACT_SCHED_NEW;
        state_next = S_FINISH;
      end
      S_BLOCK: begin
        cmd.block  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.publish = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  `TTRR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request did not raise busy")
  `TTRR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `TTRR_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `TTRR_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, !(cmd.load && cmd.adv), "load and advance together")

endmodule

[design/task_table_round_robin_scheduler.sv]
// top level of the task table round-robin scheduler
// depends on ttrr_pkg, ttrr_controller and ttrr_datapath
//
// A request (mode, slot, target, status) is taken on a rising edge where
// start is high and busy is low. busy stays high while the request works
// through the table; one result (ok, result_slot, result_status,
// ready_count, switch_count) then appears for exactly one cycle with done
// high. The receiver cannot stall, so no result is ever held back, and a new
// request may be issued in the same cycle that done is high.
// Steps per request, with N task slots (16 here):
//   alloc, reap: scan from slot 0 to the first match or to slot N - 1
//   schedule:    cyclic scan from the slot after the running one, then two table writes
//   mark exit:   exit write, then parent wake; block: one write; bad slot or mode: none
// The table has one access port, so scans visit one slot per cycle.
// Synchronous reset puts slot 0 in the running state, frees the others,
// and clears all counters.

module task_table_round_robin_scheduler (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [3:0]         slot,
  input  logic [3:0]         target,
  input  logic signed [31:0] status,
  output logic               done,
  output logic               ok,
  output logic [3:0]         result_slot,
  output logic signed [31:0] result_status,
  output logic [4:0]         ready_count,
  output logic [31:0]        switch_count
);
  import ttrr_pkg::*;

  ttrr_cmd_t  cmd;
  ttrr_stat_t stat;

  // sequencer
  ttrr_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // task table and result path
  ttrr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .slot          (slot),
    .target        (target),
    .status        (status),
    .ok            (ok),
    .result_slot   (result_slot),
    .result_status (result_status),
    .ready_count   (ready_count),
    .switch_count  (switch_count)
  );

endmodule
